/* rtl/trd_pkg.sv */
// Shared types and constants for the TGA run-length packet decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package trd_pkg;

    // Register map: register index is byte address divided by four
    typedef enum logic {
        REG_BYTES_PER_PIXEL = 1'b0,
        REG_PIXEL_TOTAL     = 1'b1
    } reg_index_t;

    localparam int          DEF_MAX_PIXEL_BYTES = 4;
    localparam int          ADDR_W              = 3;
    localparam logic [2:0]  BPP_RESET           = 3'd3;
    localparam logic [31:0] TOTAL_RESET         = 32'd1;
    localparam logic [7:0]  RUN_FLAG            = 8'h80;
    localparam logic [6:0]  COUNT_MASK          = 7'h7F;

    // Configuration handed from the register block to the decoder core
    typedef struct packed {
        logic [2:0]  bpp_raw;      // bytes per pixel as written
        logic [31:0] total_eff;    // pixel total, zero treated as one
        logic        reload;       // pixel total written in this cycle
        logic [31:0] reload_value; // effective value of that write
    } cfg_t;

    // Pixel total with zero treated as one
    function automatic logic [31:0] eff_total(input logic [31:0] total);
        eff_total = (total == 32'd0) ? 32'd1 : total;
    endfunction

endpackage

`default_nettype wire

/* rtl/trd_cfg_regs.sv */
// APB-style configuration registers of the TGA run-length packet decoder.
// Depends on trd_pkg for the register map and the cfg_t struct.
`default_nettype none

module trd_cfg_regs
    import trd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [2:0]  bpp_reg;
    logic [31:0] total_reg;
    logic        wr_en;
    reg_index_t  wr_index;

    assign pready   = 1'b1;
    assign wr_en    = psel & penable & pwrite & pready;
    assign wr_index = reg_index_t'(paddr[2]);

    // Write registers on the access beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg   <= BPP_RESET;
            total_reg <= TOTAL_RESET;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_BYTES_PER_PIXEL: bpp_reg   <= pwdata[2:0];
                REG_PIXEL_TOTAL:     total_reg <= pwdata;
                default:             ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (wr_index)
            REG_BYTES_PER_PIXEL: prdata = {29'd0, bpp_reg};
            REG_PIXEL_TOTAL:     prdata = total_reg;
            default:             prdata = 32'd0;
        endcase
    end

    // Hand configuration and the reload strobe to the core
    always_comb begin
        cfg.bpp_raw      = bpp_reg;
        cfg.total_eff    = eff_total(total_reg);
        cfg.reload       = wr_en && (wr_index == REG_PIXEL_TOTAL);
        cfg.reload_value = eff_total(pwdata);
    end

endmodule

`default_nettype wire

/* rtl/trd_core.sv */
// Packet parser, pixel assembler and result register of the decoder.
// Depends on trd_pkg for constants and the cfg_t struct.
`default_nettype none

module trd_core
    import trd_pkg::*;
#(
    parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_pixel_value,
    output logic [7:0]       m_repeat_count,
    output logic             m_image_done
);

    localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int BW = $clog2(MAX_PIXEL_BYTES + 1) + 1;
    localparam logic [BW-1:0] MAX_BPP = BW'(MAX_PIXEL_BYTES);

    logic          in_packet_reg, in_packet_next;
    logic          run_kind_reg, run_kind_next;
    logic [7:0]    ppl_reg, ppl_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [31:0]   gather_reg, gather_next;
    logic [31:0]   img_left_reg, img_left_next;
    logic          dropping_reg, dropping_next;

    logic          m_valid_reg;
    logic [31:0]   pixel_reg, pixel_next;
    logic [7:0]    count_reg, count_next;
    logic          done_reg, done_next;

    logic          acc;
    logic          produce;
    logic [BW-1:0] bpp;
    logic [BW-1:0] pos_plus;
    logic [31:0]   byte_shifted;
    logic [7:0]    ppl_dec;
    logic [7:0]    run_cnt;
    logic [7:0]    cnt;
    logic [31:0]   img_sub;

    assign s_ready = !m_valid_reg || m_ready;
    assign acc     = s_valid && s_ready;

    // Clamp bytes per pixel into 1..MAX_PIXEL_BYTES
    always_comb begin
        bpp = BW'(cfg.bpp_raw);
        if (bpp == '0) begin
            bpp = BW'(1);
        end
        if (bpp > MAX_BPP) begin
            bpp = MAX_BPP;
        end
    end

    assign pos_plus     = BW'(pos_reg) + BW'(1);
    assign byte_shifted = {24'd0, s_in_byte} << {pos_reg, 3'b000};
    assign ppl_dec      = (ppl_reg != 8'd0) ? ppl_reg - 8'd1 : 8'd0;
    assign run_cnt      = (ppl_reg == 8'd0) ? 8'd1 : ppl_reg;

    // Parse one stream beat
    always_comb begin
        in_packet_next = in_packet_reg;
        run_kind_next  = run_kind_reg;
        ppl_next       = ppl_reg;
        pos_next       = pos_reg;
        gather_next    = gather_reg;
        img_left_next  = img_left_reg;
        dropping_next  = dropping_reg;
        produce        = 1'b0;
        pixel_next     = gather_reg | byte_shifted;
        cnt            = 8'd1;
        img_sub        = img_left_reg;
        done_next      = 1'b0;

        if (acc) begin
            priority if (!in_packet_reg) begin
                // Header byte: kind and pixel count
                run_kind_next  = (s_in_byte & RUN_FLAG) != 8'd0;
                ppl_next       = {1'b0, s_in_byte[6:0] & COUNT_MASK} + 8'd1;
                pos_next       = '0;
                gather_next    = '0;
                in_packet_next = 1'b1;
                dropping_next  = 1'b0;
            end else if (pos_plus < bpp) begin
                // Gather an inner byte of the pixel
                if (!dropping_reg) begin
                    gather_next = gather_reg | byte_shifted;
                end
                pos_next = PW'(pos_plus);
            end else if (dropping_reg) begin
                // Drop the leftover pixel of a finished image
                pos_next    = '0;
                gather_next = '0;
                ppl_next    = ppl_dec;
                if (ppl_dec == 8'd0) begin
                    dropping_next  = 1'b0;
                    in_packet_next = 1'b0;
                end
            end else begin
                // Pixel complete: emit it with its clamped count
                pos_next    = '0;
                gather_next = '0;
                produce     = 1'b1;
                if (run_kind_reg) begin
                    cnt = run_cnt;
                    if ({24'd0, run_cnt} > img_left_reg) begin
                        cnt = img_left_reg[7:0];
                    end
                    ppl_next = 8'd0;
                end else begin
                    cnt      = 8'd1;
                    ppl_next = ppl_dec;
                end
                img_sub       = img_left_reg - {24'd0, cnt};
                done_next     = (img_sub == 32'd0);
                img_left_next = img_sub;
                if (done_next) begin
                    img_left_next = cfg.total_eff;
                    if (ppl_next != 8'd0) begin
                        dropping_next = 1'b1;
                    end else begin
                        in_packet_next = 1'b0;
                    end
                end else if (ppl_next == 8'd0) begin
                    in_packet_next = 1'b0;
                end
            end
        end

        // Reload the image counter on a pixel total write
        if (cfg.reload) begin
            img_left_next = cfg.reload_value;
        end
        count_next = cnt;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg <= 1'b0;
            run_kind_reg  <= 1'b0;
            ppl_reg       <= 8'd0;
            pos_reg       <= '0;
            img_left_reg  <= eff_total(TOTAL_RESET);
            dropping_reg  <= 1'b0;
        end else begin
            in_packet_reg <= in_packet_next;
            run_kind_reg  <= run_kind_next;
            ppl_reg       <= ppl_next;
            pos_reg       <= pos_next;
            img_left_reg  <= img_left_next;
            dropping_reg  <= dropping_next;
        end
    end

    // Gathered bytes need no reset: a header clears them
    always_ff @(posedge aclk) begin
        gather_reg <= gather_next;
    end

    // Result register: load on a finished pixel, drop on the taken beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (produce) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            pixel_reg <= pixel_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_value  = pixel_reg;
    assign m_repeat_count = count_reg;
    assign m_image_done   = done_reg;

    // Checks
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (count_reg != 8'd0))
        else $error("result beat with zero repeat count");

    a_drop_in_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        dropping_reg |-> in_packet_reg)
        else $error("dropping outside a packet");

    a_header_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && !in_packet_reg && !cfg.reload) |=> (in_packet_reg && !dropping_reg))
        else $error("header beat did not open a packet");

    a_img_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        img_left_reg != 32'd0)
        else $error("image pixel counter reached zero without reload");

    a_ppl_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ppl_reg <= 8'd128)
        else $error("packet pixel count out of range");

endmodule

`default_nettype wire

/* rtl/tga_rle_packet_decoder.sv */
// TGA run-length packet decoder: one compressed byte per beat, one result per pixel.
// A pixel's result is registered and appears in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; bytes are taken while a result waits as long
// as the single result register is free or being taken in that cycle.
// Reset (aresetn low, synchronous): next byte is a header, registers return to
// 3 bytes per pixel and a pixel total of 1, no result pending.
`default_nettype none

module tga_rle_packet_decoder
    import trd_pkg::*;
#(
    parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_in_byte,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [31:0]            m_pixel_value,
    output logic [7:0]             m_repeat_count,
    output logic                   m_image_done
);

    cfg_t cfg;

    // Configuration registers
    trd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Packet parser and result register
    trd_core #(
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_value  (m_pixel_value),
        .m_repeat_count (m_repeat_count),
        .m_image_done   (m_image_done)
    );

endmodule

`default_nettype wire

/* test/trd_stream_checker.sv */
`timescale 1ns / 1ps
// Result checker for the TGA run-length packet decoder: watches the register port
// and both streams, predicts each pixel result and compares it. Depends on trd_pkg.

module trd_stream_checker
    import trd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    input  wire logic              pready,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic [7:0]        s_in_byte,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire logic [31:0]       m_pixel_value,
    input  wire logic [7:0]        m_repeat_count,
    input  wire logic              m_image_done,
    output int                     fail_count,
    output int                     pending,
    output int                     results_seen,
    output int                     images_seen
);

    localparam logic [2:0] MAX_BYTES = 3'(DEF_MAX_PIXEL_BYTES);

    typedef struct packed {
        logic [31:0] pixel_value;
        logic [7:0]  repeat_count;
        logic        image_done;
    } pixel_result_t;

    // Register copies
    logic [2:0]  bpp_reg;
    logic [31:0] total_reg;

    // Decoder state
    logic        in_pkt;
    logic        run_pkt;
    logic [7:0]  pkt_left;
    logic [1:0]  byte_pos;
    logic [31:0] gather;
    logic [31:0] image_left;
    logic        dropping;

    pixel_result_t pending_pixels[$];

    function automatic logic [31:0] image_size();
        return (total_reg == 32'd0) ? 32'd1 : total_reg;
    endfunction

    // Advance the decoder by one stream byte; emit is set when a pixel completes
    function automatic void decode_byte(input logic [7:0] b, output logic emit,
                                        output pixel_result_t res);
        logic [2:0]  bpp;
        logic [1:0]  pos;
        logic [31:0] count;
        emit = 1'b0;
        res  = '0;
        bpp  = (bpp_reg == 3'd0) ? 3'd1 : (bpp_reg > MAX_BYTES) ? MAX_BYTES : bpp_reg;

        // Header byte: kind from the top bit, pixel count from the rest
        if (!in_pkt) begin
            run_pkt  = b[7];
            pkt_left = {1'b0, b[6:0]} + 8'd1;
            byte_pos = 2'd0;
            gather   = '0;
            in_pkt   = 1'b1;
            dropping = 1'b0;
            return;
        end

        // Pixel not complete yet: gather the byte
        if ({1'b0, byte_pos} + 3'd1 < bpp) begin
            if (!dropping)
                gather[8*byte_pos +: 8] = b;
            byte_pos = byte_pos + 2'd1;
            return;
        end

        pos      = byte_pos;
        byte_pos = 2'd0;

        // Leftover pixel of a finished image: drop it
        if (dropping) begin
            gather = '0;
            if (pkt_left != 8'd0)
                pkt_left = pkt_left - 8'd1;
            if (pkt_left == 8'd0) begin
                dropping = 1'b0;
                in_pkt   = 1'b0;
            end
            return;
        end

        gather[8*pos +: 8] = b;
        res.pixel_value    = gather;
        gather             = '0;

        // Clamp a run to what the image still needs
        if (run_pkt) begin
            count = {24'd0, pkt_left};
            if (count == 32'd0)
                count = 32'd1;
            if (count > image_left)
                count = image_left;
            pkt_left = 8'd0;
        end else begin
            count = 32'd1;
            if (pkt_left != 8'd0)
                pkt_left = pkt_left - 8'd1;
        end
        image_left       = image_left - count;
        res.repeat_count = count[7:0];
        res.image_done   = (image_left == 32'd0);

        if (res.image_done) begin
            image_left = image_size();
            if (pkt_left != 8'd0)
                dropping = 1'b1;
            else
                in_pkt = 1'b0;
        end else if (pkt_left == 8'd0) begin
            in_pkt = 1'b0;
        end
        emit = 1'b1;
    endfunction

    always @(posedge aclk) begin : watch
        pixel_result_t fresh;
        pixel_result_t want;
        logic          emit;
        if (!aresetn) begin
            bpp_reg    = BPP_RESET;
            total_reg  = TOTAL_RESET;
            in_pkt     = 1'b0;
            run_pkt    = 1'b0;
            pkt_left   = '0;
            byte_pos   = '0;
            gather     = '0;
            dropping   = 1'b0;
            image_left = image_size();
            pending_pixels.delete();
        end else begin
            // Track register writes
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[ADDR_W-1:2]))
                    REG_BYTES_PER_PIXEL: begin
                        bpp_reg = pwdata[2:0];
                    end
                    REG_PIXEL_TOTAL: begin
                        total_reg  = pwdata;
                        image_left = image_size();
                    end
                    default: ;
                endcase
            end

            // Compare a result beat with the oldest expected pixel
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_image_done)
                    images_seen++;
                if (pending_pixels.size() == 0) begin
                    $error("unexpected result: pixel_value %h repeat_count %0d image_done %0b",
                           m_pixel_value, m_repeat_count, m_image_done);
                    fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (m_pixel_value !== want.pixel_value) begin
                        $error("pixel_value: expected %h, got %h",
                               want.pixel_value, m_pixel_value);
                        fail_count++;
                    end
                    if (m_repeat_count !== want.repeat_count) begin
                        $error("repeat_count: expected %0d, got %0d",
                               want.repeat_count, m_repeat_count);
                        fail_count++;
                    end
                    if (m_image_done !== want.image_done) begin
                        $error("image_done: expected %0b, got %0b",
                               want.image_done, m_image_done);
                        fail_count++;
                    end
                end
            end

            // Predict from an accepted stream byte
            if (s_valid && s_ready) begin
                decode_byte(s_in_byte, emit, fresh);
                if (emit)
                    pending_pixels.push_back(fresh);
            end
        end
        pending <= pending_pixels.size();
    end

endmodule

/* test/tb_tga_rle_packet_decoder.sv */
`timescale 1ns / 1ps
// Testbench top for the TGA run-length packet decoder: drives the byte stream, the
// register port, result back-pressure. Uses trd_pkg, trd_stream_checker and the DUT.

module tb_tga_rle_packet_decoder;
    import trd_pkg::*;

    localparam int ITEM_COUNT      = 2000;
    localparam int PRESSURE_AT     = 600;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 3000;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic [7:0]        s_in_byte = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [31:0]       m_pixel_value;
    logic [7:0]        m_repeat_count;
    logic              m_image_done;

    int fail_count;
    int pending;
    int results_seen;
    int images_seen;
    int bytes_sent   = 0;
    int cfg_writes   = 0;
    int pixel_bytes  = 3;
    int steady_left  = 0;
    bit held_off     = 1'b0;

    tga_rle_packet_decoder dut (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_valid, .s_ready, .s_in_byte,
        .m_valid, .m_ready, .m_pixel_value, .m_repeat_count, .m_image_done
    );

    trd_stream_checker u_check (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .s_valid, .s_ready, .s_in_byte,
        .m_valid, .m_ready, .m_pixel_value, .m_repeat_count, .m_image_done,
        .fail_count, .pending, .results_seen, .images_seen
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one stream byte and hold it until the beat is taken
    task automatic send_byte(input logic [7:0] b);
        if (steady_left > 0) begin
            steady_left--;
        end else if ($urandom_range(15) == 0) begin
            steady_left = $urandom_range(20, 100);
        end else if ($urandom_range(3) == 0) begin
            s_valid <= 1'b0;
            repeat (pick_gap()) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Drop valid and wait until every expected pixel has come out
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input reg_index_t idx, input logic [31:0] data);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_writes++;
        if (idx == REG_BYTES_PER_PIXEL)
            pixel_bytes = (data[2:0] == 3'd0) ? 1 :
                          (data[2:0] > 3'(DEF_MAX_PIXEL_BYTES)) ? DEF_MAX_PIXEL_BYTES :
                          int'(data[2:0]);
    endtask

    // One well-formed packet with random content, or a burst of noise
    task automatic send_packet();
        logic       run;
        logic [6:0] span;
        int         body;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end else begin
            run  = 1'($urandom_range(1));
            span = ($urandom_range(15) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(7));
            body = run ? pixel_bytes : (int'(span) + 1) * pixel_bytes;
            send_byte({run, span});
            repeat (body) send_byte(pick_byte());
        end
    endtask

    // Pick a new register setting between phases
    task automatic new_setting();
        int          which;
        logic [31:0] total;
        which = $urandom_range(2);
        if (which != 1)
            cfg_write(REG_BYTES_PER_PIXEL, ($urandom & ~32'h7) | 32'($urandom_range(7)));
        if (which != 0) begin
            case ($urandom_range(7))
                0:       total = 32'd1;
                1:       total = 32'd0;
                2:       total = 32'hFFFF_FFFF;
                3:       total = $urandom;
                default: total = 32'($urandom_range(2, 60));
            endcase
            cfg_write(REG_PIXEL_TOTAL, total);
        end
    endtask

    // Result side: random stalls, ready stretches, one long hold-off
    initial begin : result_sink
        @(posedge aclk iff aresetn);
        forever begin
            if (!held_off && bytes_sent >= PRESSURE_AT && s_valid) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                held_off = 1'b1;
            end else if ($urandom_range(9) < 3) begin
                m_ready <= 1'b0;
                repeat (pick_gap()) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat (($urandom_range(7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20))
                @(posedge aclk);
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no progress for %0d cycles, %0d results outstanding", WATCHDOG_LIMIT, pending);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting: a full-length run clamped to a one-pixel image
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h7F);

        // Zero total acts as one: image ends inside a raw packet, rest dropped
        cfg_write(REG_BYTES_PER_PIXEL, 32'd4);
        cfg_write(REG_PIXEL_TOTAL, 32'd0);
        send_byte(8'h01);
        repeat (4) send_byte(8'hFF);
        repeat (4) send_byte(8'h00);

        // Zero pixel size acts as one byte; maximum total; longest run
        cfg_write(REG_BYTES_PER_PIXEL, 32'd0);
        cfg_write(REG_PIXEL_TOTAL, 32'hFFFF_FFFF);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h7F);

        // Oversized pixel size clamps to four; shrink it in the middle of a pixel
        cfg_write(REG_BYTES_PER_PIXEL, 32'd7);
        send_byte(8'h00);
        send_byte(8'h5A);
        cfg_write(REG_BYTES_PER_PIXEL, 32'hFFFF_FFFA);
        send_byte(8'hA5);

        // Random phases, each under its own register setting
        while (bytes_sent < ITEM_COUNT + 20) begin
            new_setting();
            repeat ($urandom_range(4, 16)) send_packet();
        end

        settle();
        repeat (8) @(posedge aclk);
        $display("Run covered %0d stream bytes, %0d pixel results, %0d finished images",
                 bytes_sent, results_seen, images_seen);
        $display("over %0d register writes, including clamped sizes and totals 0 and max",
                 cfg_writes);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/trd_pkg.sv
rtl/trd_cfg_regs.sv
rtl/trd_core.sv
rtl/tga_rle_packet_decoder.sv
test/trd_stream_checker.sv
test/tb_tga_rle_packet_decoder.sv
